// ===== design/lcmc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcmc_pkg: shared constants and types for the LRU cache miss counter
// Sizes of the recency chain and the structs that run along it.
// ----------------------------------------------------------------------------
package lcmc_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_BITS  = 16;
	localparam int ID_BITS   = 16;
	localparam int CFG_BITS  = 5;
	localparam int OCC_BITS  = 5;
	localparam int MISS_BITS = 32;
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);

	// Handed from one cell to the next, front of the list first.
	typedef struct packed {
		logic [KEY_BITS-1:0] key;    // key held by the cell (or the new key at the front)
		logic                valid;  // entry valid for this access
		logic                match;  // hit seen in this cell or any cell in front
	} link_t;

	// Driven to every cell at once.
	typedef struct packed {
		logic                en;     // item accepted this cycle
		logic                start;  // list cleared before this access
		logic [KEY_BITS-1:0] key;    // key being accessed
		logic                found;  // hit anywhere in the list
		logic                full;   // miss must evict the least recent entry
	} bcast_t;

endpackage

// ===== design/lcmc_cell.sv =====
// ----------------------------------------------------------------------------
// lcmc_cell: one position of the recency list
// Holds one key and its valid bit, compares against the access key and takes
// its neighbor's entry when the list shifts through this position.
// ----------------------------------------------------------------------------
module lcmc_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  lcmc_pkg::bcast_t bc,
	input  lcmc_pkg::link_t  prev,
	output lcmc_pkg::link_t  next
);

	logic [lcmc_pkg::KEY_BITS-1:0] key_q;
	logic                          valid_q;
	logic                          valid_eff;
	logic                          match;
	logic                          shift;

	assign valid_eff = valid_q & ~bc.start;
	assign match     = valid_eff & (key_q == bc.key);

	// Hit: positions up to and including the hit shift.
	// Miss, full: every valid position shifts, the last one is dropped.
	// Miss, not full: positions up to one past the last valid shift.
	always_comb begin
		if (bc.found) begin
			shift = ~prev.match;
		end else if (bc.full) begin
			shift = valid_eff;
		end else begin
			shift = prev.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (bc.en) begin
			valid_q <= shift ? prev.valid : valid_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (bc.en && shift) begin
			key_q <= prev.key;
		end
	end

	assign next.key   = key_q;
	assign next.valid = valid_eff;
	assign next.match = prev.match | match;

endmodule

// ===== design/lru_cache_miss_counter_top.sv =====
// ----------------------------------------------------------------------------
// lru_cache_miss_counter_top: fully associative LRU cache simulator
// Recency list as a chain of cells; reports hit, saturating miss count and
// occupancy for every key access.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  s_*      | in  | s_tvalid/s_tready | tdata: camera_id; tuser: start_new
//  m_*      | out | m_tvalid/m_tready | tdata: hit, miss_count, occupancy
//  cfg_*    | in  | cfg_we            | cfg_wdata: size_limit
//
// One item per cycle while the output is not stalled; the result appears in the output
// register in the cycle after acceptance. All cells compare and shift in the cycle of acceptance.
// A stalled result holds s_tready low only while m_tready is low.
// Reset clears the valid bits, counts and output valid; size_limit resets to 16.
// ----------------------------------------------------------------------------
module lru_cache_miss_counter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] camera_id
	input  logic        s_tuser,   // [0] start_new
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [0] hit, [32:1] miss_count, [37:33] occupancy, rest 0
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata  // size_limit
);

	logic [lcmc_pkg::CFG_BITS-1:0]  size_limit_q;
	logic [lcmc_pkg::CNT_BITS-1:0]  vc_q;
	logic [lcmc_pkg::MISS_BITS-1:0] miss_q;
	logic                           out_valid_q;
	logic                           hit_q;
	logic [lcmc_pkg::MISS_BITS-1:0] miss_out_q;
	logic [lcmc_pkg::OCC_BITS-1:0]  occ_q;

	logic                           accept;
	logic [lcmc_pkg::CNT_BITS-1:0]  limit;
	logic [lcmc_pkg::CNT_BITS-1:0]  vc_eff;
	logic [lcmc_pkg::CNT_BITS-1:0]  vc_next;
	logic [lcmc_pkg::MISS_BITS-1:0] miss_base;
	logic [lcmc_pkg::MISS_BITS-1:0] miss_next;
	lcmc_pkg::bcast_t               bc;
	lcmc_pkg::link_t                chain [lcmc_pkg::CAPACITY+1];

	assign s_tready = ~out_valid_q | m_tready;
	assign accept   = s_tvalid & s_tready;

	// Zero acts as one, anything above the list size as the list size.
	always_comb begin
		if (size_limit_q == '0) begin
			limit = lcmc_pkg::CNT_BITS'(1);
		end else if (32'(size_limit_q) > lcmc_pkg::CAPACITY) begin
			limit = lcmc_pkg::CNT_BITS'(lcmc_pkg::CAPACITY);
		end else begin
			limit = lcmc_pkg::CNT_BITS'(size_limit_q);
		end
	end

	assign vc_eff    = s_tuser ? '0 : vc_q;
	assign miss_base = s_tuser ? '0 : miss_q;

	assign bc.en    = accept;
	assign bc.start = s_tuser;
	assign bc.key   = s_tdata[lcmc_pkg::KEY_BITS-1:0];
	assign bc.found = chain[lcmc_pkg::CAPACITY].match;
	assign bc.full  = (vc_eff >= limit);

	// Front of the chain feeds the new key in.
	assign chain[0].key   = s_tdata[lcmc_pkg::KEY_BITS-1:0];
	assign chain[0].valid = 1'b1;
	assign chain[0].match = 1'b0;

	for (genvar i = 0; i < lcmc_pkg::CAPACITY; i++) begin : g_cell
		lcmc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.bc     (bc),
			.prev   (chain[i]),
			.next   (chain[i+1])
		);
	end

	always_comb begin
		vc_next   = vc_eff;
		miss_next = miss_base;
		if (!bc.found) begin
			if (miss_base != '1) begin
				miss_next = miss_base + lcmc_pkg::MISS_BITS'(1);
			end
			if (!bc.full) begin
				vc_next = vc_eff + lcmc_pkg::CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_limit_q <= lcmc_pkg::CFG_BITS'(16);
		end else if (cfg_we) begin
			size_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q        <= '0;
			miss_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				vc_q   <= vc_next;
				miss_q <= miss_next;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q      <= bc.found;
			miss_out_q <= miss_next;
			occ_q      <= lcmc_pkg::OCC_BITS'(vc_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, occ_q, miss_out_q, hit_q};

endmodule

// ===== verif/lru_cache_miss_counter_top_tb.sv =====
// ----------------------------------------------------------------------------
// lru_cache_miss_counter_top_tb: self-checking bench for the LRU miss counter
// Streams key accesses with random gaps and back-pressure, predicts hit,
// miss count and occupancy with a behavioral recency list, and compares
// every result item in order. The size limit is changed between idle phases.
// ----------------------------------------------------------------------------
module lru_cache_miss_counter_top_tb;
	import lcmc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_STALL     = 400;

	typedef struct {
		logic [ID_BITS-1:0] id;
		logic               start;
	} access_t;

	typedef struct {
		logic                 hit;
		logic [MISS_BITS-1:0] misses;
		logic [OCC_BITS-1:0]  occ;
	} outcome_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [4:0]  cfg_wdata = '0;

	// behavioral recency list, front at index 0
	logic [KEY_BITS-1:0]  lru_keys [CAPACITY];
	int                   lru_count  = 0;
	logic [MISS_BITS-1:0] lru_misses = '0;
	logic [CFG_BITS-1:0]  lru_size   = 5'd16;

	access_t  pending_access [$];
	outcome_t expected_outcome [$];
	access_t  tx_item;
	outcome_t want;
	int       errors     = 0;
	int       tx_wait    = 0;
	int       rx_wait    = 0;
	int       stall_ask  = 0;
	int       stall_seen = 0;
	int       quiet      = 0;
	bit       idle_on    = 1'b1;

	lru_cache_miss_counter_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic outcome_t lru_access(logic [ID_BITS-1:0] id, logic start);
		outcome_t            r;
		logic [KEY_BITS-1:0] key;
		int                  lim;
		int                  pos;
		int                  upto;
		bit                  found;
		key = id[KEY_BITS-1:0];
		if (start) begin
			lru_count  = 0;
			lru_misses = '0;
		end
		lim = lru_size;
		if (lim == 0) lim = 1;
		if (lim > CAPACITY) lim = CAPACITY;
		found = 1'b0;
		pos   = 0;
		for (int i = 0; i < lru_count; i++) begin
			if (!found && lru_keys[i] == key) begin
				found = 1'b1;
				pos   = i;
			end
		end
		if (found) begin
			upto = pos;
		end else begin
			if (lru_misses != '1) lru_misses++;
			// a full list (or one left over-full by a lowered size) drops its tail
			if (lru_count >= lim) begin
				upto = lru_count - 1;
			end else begin
				upto = lru_count;
				lru_count++;
			end
		end
		for (int i = upto; i > 0; i--) begin
			if (i < CAPACITY) lru_keys[i] = lru_keys[i-1];
		end
		lru_keys[0] = key;
		r.hit    = found;
		r.misses = lru_misses;
		r.occ    = lru_count[OCC_BITS-1:0];
		return r;
	endfunction

	// sender: holds an item until accepted, random gaps between items
	always @(posedge clk) begin
		if (!s_tvalid || s_tready) begin
			if (tx_wait > 0) begin
				tx_wait--;
				s_tvalid <= 1'b0;
			end else if (pending_access.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
				tx_wait = $urandom_range(0, 16);
				s_tvalid <= 1'b0;
			end else if (pending_access.size() != 0) begin
				tx_item = pending_access.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= tx_item.id;
				s_tuser  <= tx_item.start;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver back-pressure, plus one long hold-off on request
	always @(posedge clk) begin
		if (stall_ask != stall_seen) begin
			stall_seen = stall_ask;
			rx_wait    = LONG_STALL;
		end
		if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rx_wait = $urandom_range(0, 16);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result check first, so a stray result is never matched to this edge's item
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_outcome.size() == 0) begin
					$display("%0t: unexpected result item %h", $realtime, m_tdata);
					errors++;
				end else begin
					want = expected_outcome.pop_front();
					if (m_tdata[0] !== want.hit) begin
						$display("%0t: hit expected %0d actual %0d", $realtime, want.hit,
							m_tdata[0]);
						errors++;
					end
					if (m_tdata[32:1] !== want.misses) begin
						$display("%0t: miss_count expected %0d actual %0d", $realtime,
							want.misses, m_tdata[32:1]);
						errors++;
					end
					if (m_tdata[37:33] !== want.occ) begin
						$display("%0t: occupancy expected %0d actual %0d", $realtime,
							want.occ, m_tdata[37:33]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_outcome.insert(expected_outcome.size(),
					lru_access(s_tdata, s_tuser));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $realtime, quiet);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic push_access(input logic [ID_BITS-1:0] id, input logic start);
		access_t a;
		a.id    = id;
		a.start = start;
		pending_access.insert(pending_access.size(), a);
	endtask

	// sender and receiver both drained, block idle
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_access.size() != 0 || s_tvalid || expected_outcome.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_size(input logic [CFG_BITS-1:0] size);
		wait_idle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= size;
		lru_size  = size;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_random(input logic [CFG_BITS-1:0] size, input int count,
			input bit long_stall);
		logic [ID_BITS-1:0] pool [20];
		int                 span;
		logic [ID_BITS-1:0] id;
		write_size(size);
		span = (size == 0) ? 1 : (size > CAPACITY) ? CAPACITY : size;
		span = span + 3;
		if (span > 19) span = 19;
		foreach (pool[k]) pool[k] = ID_BITS'($urandom_range(0, 65535));
		for (int n = 0; n < count; n++) begin
			// mostly a small key pool so hits and evictions both happen
			if ($urandom_range(0, 9) == 0) id = ID_BITS'($urandom_range(0, 65535));
			else id = pool[$urandom_range(0, span)];
			push_access(id, $urandom_range(0, 39) == 0);
		end
		if (long_stall) stall_ask++;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// size 16 out of reset: key extremes, hits, start on a present key
		push_access(16'h0000, 1'b1);
		push_access(16'hFFFF, 1'b0);
		push_access(16'h0000, 1'b0);
		push_access(16'hFFFF, 1'b0);
		push_access(16'h5555, 1'b0);
		push_access(16'hAAAA, 1'b0);
		push_access(16'hAAAA, 1'b1);

		// size zero acts as one
		write_size(5'd0);
		push_access(16'h0011, 1'b0);
		push_access(16'h0011, 1'b0);
		push_access(16'h0022, 1'b0);

		// size above capacity clamps
		write_size(5'd31);
		push_access(16'h0100, 1'b1);
		for (int k = 1; k <= 5; k++) push_access(ID_BITS'(16'h0100 + k), 1'b0);

		// size lowered below occupancy: misses keep the count
		write_size(5'd2);
		push_access(16'h0200, 1'b0);
		push_access(16'h0101, 1'b0);
		push_access(16'h0300, 1'b0);

		run_random(5'd16, 160, 1'b0);
		run_random(5'd1,  160, 1'b0);
		run_random(5'd4,  160, 1'b1);
		run_random(5'd0,  160, 1'b0);
		run_random(5'd31, 160, 1'b0);
		run_random(5'd2,  160, 1'b0);
		run_random(5'd8,  160, 1'b0);
		run_random(5'd17, 160, 1'b0);
		run_random(CFG_BITS'($urandom_range(0, 31)), 160, 1'b0);
		run_random(CFG_BITS'($urandom_range(0, 31)), 160, 1'b0);
		idle_on = 1'b0;
		run_random(5'd16, 200, 1'b0);

		wait_idle();
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (expected_outcome.size() != 0) begin
			$display("%0t: %0d results never arrived", $realtime, expected_outcome.size());
			errors++;
		end
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
